// ===== design/mcsr_pkg.sv =====
// Package for the machine-mode CSR file: request and status codes, CSR addresses,
// write masks and fixed values. No dependencies.
package mcsr_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FETCH = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_READ_ONLY = 2'd2
    } t_status;

    localparam logic [11:0] CSR_MSTATUS   = 12'h300;
    localparam logic [11:0] CSR_MISA      = 12'h301;
    localparam logic [11:0] CSR_MIE       = 12'h304;
    localparam logic [11:0] CSR_MTVEC     = 12'h305;
    localparam logic [11:0] CSR_MSCRATCH  = 12'h340;
    localparam logic [11:0] CSR_MEPC      = 12'h341;
    localparam logic [11:0] CSR_MCAUSE    = 12'h342;
    localparam logic [11:0] CSR_MTVAL     = 12'h343;
    localparam logic [11:0] CSR_MIP       = 12'h344;
    localparam logic [11:0] CSR_MVENDORID = 12'hF11;
    localparam logic [11:0] CSR_MARCHID   = 12'hF12;
    localparam logic [11:0] CSR_MIMPID    = 12'hF13;
    localparam logic [11:0] CSR_MHARTID   = 12'hF14;

    localparam int unsigned XLEN        = 64;
    localparam int unsigned MSTATUS_W   = 34;
    localparam int unsigned INT_W       = 12;

    localparam logic [MSTATUS_W-1:0] MSTATUS_FIXED = 34'h2_0000_0000;
    localparam logic [MSTATUS_W-1:0] MSTATUS_WMASK = 34'h0_0000_1888;
    localparam logic [MSTATUS_W-1:0] TRAP_MSTATUS  = 34'h2_0000_1800;
    localparam logic [INT_W-1:0]     INT_WMASK     = 12'h999;
    localparam logic [XLEN-1:0]      ALIGN4_MASK   = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [XLEN-1:0]      VECTORED_MASK = 64'hFFFF_FFFF_FFFF_FF01;
    localparam logic [XLEN-1:0]      CAUSE_MASK    = 64'h8000_0000_0000_000F;
    localparam logic [XLEN-1:0]      IMPL_ID       = 64'h2018_0200_0000_0000;

endpackage

// ===== design/mcsr_req_if.sv =====
// Request channel of the machine-mode CSR file: valid/ready plus request payload.
// No dependencies.
interface mcsr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] csr_addr;
    logic [63:0] write_data;
    logic [63:0] fetch_pc;

    modport source (output valid, output req_type, output csr_addr,
                    output write_data, output fetch_pc, input ready);
    modport sink   (input valid, input req_type, input csr_addr,
                    input write_data, input fetch_pc, output ready);
endinterface

// ===== design/mcsr_rsp_if.sv =====
// Response channel of the machine-mode CSR file: valid/ready plus result payload.
// No dependencies.
interface mcsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [1:0]  status;
    logic        trap_taken;
    logic [63:0] redirect_pc;

    modport source (output valid, output read_data, output status,
                    output trap_taken, output redirect_pc, input ready);
    modport sink   (input valid, input read_data, input status,
                    input trap_taken, input redirect_pc, output ready);
endinterface

// ===== design/machine_csr_file_with_fetch_trap.sv =====
// Machine-mode CSR file of a 64-bit core with a misaligned-fetch trap.
// Depends on mcsr_pkg, mcsr_req_if and mcsr_rsp_if.
//
// Usage:
//   i_req carries one transaction per request: a CSR read, a CSR write or a
//   fetch-address check. o_rsp returns exactly one transaction per request,
//   in order: read data, a status code, a trap flag and the redirect target.
//   i_cfg_we/i_cfg_wdata load the value that misa reads back; write it only
//   while no request is outstanding.
// Timing:
//   A request is captured in an input register, evaluated against the CSR
//   state combinationally, and its result is registered in the output
//   register, from which o_rsp takes it. One request per cycle is sustained
//   while o_rsp.ready stays high; one CSR update per cycle.
// Reset:
//   i_rst_n (synchronous, active low) clears every CSR, the misa value and
//   the valid flags of both pipeline registers.
// Stall:
//   While o_rsp.ready is low the result holds; the input register still
//   takes one more transaction, then i_req.ready drops until the result moves.
module machine_csr_file_with_fetch_trap
    import mcsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [XLEN-1:0]   i_cfg_wdata,
    mcsr_req_if.sink          i_req,
    mcsr_rsp_if.source        o_rsp
);

    logic                 r_in_valid;
    logic [1:0]           r_req_type;
    logic [11:0]          r_csr_addr;
    logic [XLEN-1:0]      r_write_data;
    logic [XLEN-1:0]      r_fetch_pc;

    logic                 r_out_valid;
    logic [XLEN-1:0]      r_read_data;
    t_status              r_status;
    logic                 r_trap_taken;
    logic [XLEN-1:0]      r_redirect_pc;

    logic [XLEN-1:0]      r_misa;
    logic [MSTATUS_W-1:0] r_mstatus, n_mstatus;
    logic [INT_W-1:0]     r_mie, n_mie;
    logic [INT_W-1:0]     r_mip, n_mip;
    logic [XLEN-1:0]      r_mtvec, n_mtvec;
    logic [XLEN-1:0]      r_mscratch, n_mscratch;
    logic [XLEN-1:0]      r_mepc, n_mepc;
    logic [XLEN-1:0]      r_mcause, n_mcause;
    logic [XLEN-1:0]      r_mtval, n_mtval;

    logic                 advance;
    logic [XLEN-1:0]      n_read_data;
    t_status              n_status;
    logic                 n_trap_taken;
    logic [XLEN-1:0]      n_redirect_pc;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type   <= i_req.req_type;
            r_csr_addr   <= i_req.csr_addr;
            r_write_data <= i_req.write_data;
            r_fetch_pc   <= i_req.fetch_pc;
        end
    end

    always_comb begin
        n_mstatus     = r_mstatus;
        n_mie         = r_mie;
        n_mip         = r_mip;
        n_mtvec       = r_mtvec;
        n_mscratch    = r_mscratch;
        n_mepc        = r_mepc;
        n_mcause      = r_mcause;
        n_mtval       = r_mtval;
        n_read_data   = '0;
        n_status      = ST_OK;
        n_trap_taken  = 1'b0;
        n_redirect_pc = '0;
        case (r_req_type)
            REQ_READ: begin
                case (r_csr_addr)
                    CSR_MVENDORID, CSR_MARCHID, CSR_MHARTID: n_read_data = '0;
                    CSR_MIMPID:   n_read_data = IMPL_ID;
                    CSR_MSTATUS:  n_read_data = {{(XLEN-MSTATUS_W){1'b0}}, r_mstatus};
                    CSR_MISA:     n_read_data = r_misa;
                    CSR_MIE:      n_read_data = {{(XLEN-INT_W){1'b0}}, r_mie};
                    CSR_MTVEC:    n_read_data = r_mtvec;
                    CSR_MSCRATCH: n_read_data = r_mscratch;
                    CSR_MEPC:     n_read_data = r_mepc;
                    CSR_MCAUSE:   n_read_data = r_mcause;
                    CSR_MTVAL:    n_read_data = r_mtval;
                    CSR_MIP:      n_read_data = {{(XLEN-INT_W){1'b0}}, r_mip};
                    default:      n_status    = ST_UNKNOWN;
                endcase
            end
            REQ_WRITE: begin
                case (r_csr_addr)
                    CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID:
                        n_status = ST_READ_ONLY;
                    CSR_MSTATUS:
                        n_mstatus = MSTATUS_FIXED | (r_write_data[MSTATUS_W-1:0] & MSTATUS_WMASK);
                    CSR_MISA: n_status = ST_OK;
                    CSR_MIE:  n_mie = r_write_data[INT_W-1:0] & INT_WMASK;
                    CSR_MTVEC: begin
                        if (r_write_data[0]) begin
                            n_mtvec = r_write_data & VECTORED_MASK;
                        end else begin
                            n_mtvec = r_write_data & ALIGN4_MASK;
                        end
                    end
                    CSR_MSCRATCH: n_mscratch = r_write_data;
                    CSR_MEPC:     n_mepc     = r_write_data & ALIGN4_MASK;
                    CSR_MCAUSE:   n_mcause   = r_write_data & CAUSE_MASK;
                    CSR_MTVAL:    n_mtval    = r_write_data;
                    CSR_MIP:      n_mip      = r_write_data[INT_W-1:0] & INT_WMASK;
                    default:      n_status   = ST_UNKNOWN;
                endcase
            end
            REQ_FETCH: begin
                if (r_fetch_pc[1:0] != 2'b00) begin
                    n_mtval       = r_fetch_pc;
                    n_mcause      = '0;
                    n_mepc        = r_fetch_pc & ALIGN4_MASK;
                    n_mstatus     = TRAP_MSTATUS;
                    n_redirect_pc = r_mtvec & ALIGN4_MASK;
                    n_trap_taken  = 1'b1;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_misa     <= '0;
            r_mstatus  <= '0;
            r_mie      <= '0;
            r_mip      <= '0;
            r_mtvec    <= '0;
            r_mscratch <= '0;
            r_mepc     <= '0;
            r_mcause   <= '0;
            r_mtval    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_misa <= i_cfg_wdata;
            end
            if (advance) begin
                r_mstatus  <= n_mstatus;
                r_mie      <= n_mie;
                r_mip      <= n_mip;
                r_mtvec    <= n_mtvec;
                r_mscratch <= n_mscratch;
                r_mepc     <= n_mepc;
                r_mcause   <= n_mcause;
                r_mtval    <= n_mtval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data   <= n_read_data;
            r_status      <= n_status;
            r_trap_taken  <= n_trap_taken;
            r_redirect_pc <= n_redirect_pc;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_read_data;
    assign o_rsp.status      = r_status;
    assign o_rsp.trap_taken  = r_trap_taken;
    assign o_rsp.redirect_pc = r_redirect_pc;

    a_mtvec_bit1_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mtvec[1] == 1'b0)
        else $error("mtvec bit 1 set");

    a_mepc_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mepc[1:0] == 2'b00)
        else $error("mepc not aligned");

    a_trap_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_trap_taken |-> r_status == ST_OK && r_redirect_pc[1:0] == 2'b00)
        else $error("trap result with bad status or redirect");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_read_data == '0 && !r_trap_taken)
        else $error("error result carries data");

    a_trap_updates_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_trap_taken |=> r_mstatus == TRAP_MSTATUS && r_mcause == '0)
        else $error("trap did not update mstatus/mcause");

endmodule

// ===== tb/mcsr_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the machine-mode CSR file: predicts each response from its own CSR state
// and compares it with what the block returns. Depends on mcsr_pkg, mcsr_req_if, mcsr_rsp_if.
module mcsr_checker
    import mcsr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [XLEN-1:0] i_cfg_wdata,
    mcsr_req_if             i_req,
    mcsr_rsp_if             i_rsp,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_traps
);

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic [1:0]      status;
        logic            trap_taken;
        logic [XLEN-1:0] redirect_pc;
    } csr_rsp_t;

    logic [XLEN-1:0]      misa_q;
    logic [MSTATUS_W-1:0] mstatus_q;
    logic [INT_W-1:0]     mie_q;
    logic [INT_W-1:0]     mip_q;
    logic [XLEN-1:0]      mtvec_q;
    logic [XLEN-1:0]      mscratch_q;
    logic [XLEN-1:0]      mepc_q;
    logic [XLEN-1:0]      mcause_q;
    logic [XLEN-1:0]      mtval_q;

    csr_rsp_t expected_rsps[$];
    csr_rsp_t got_rsp;
    csr_rsp_t want_rsp;
    csr_rsp_t new_rsp;

    task automatic predict_csr(input logic [1:0] rt, input logic [11:0] addr,
                               input logic [XLEN-1:0] wd, input logic [XLEN-1:0] pc,
                               output csr_rsp_t r);
        r = '0;
        case (rt)
            REQ_READ: begin
                case (addr)
                    CSR_MVENDORID, CSR_MARCHID, CSR_MHARTID: r.read_data = '0;
                    CSR_MIMPID:   r.read_data = IMPL_ID;
                    CSR_MSTATUS:  r.read_data = XLEN'(mstatus_q);
                    CSR_MISA:     r.read_data = misa_q;
                    CSR_MIE:      r.read_data = XLEN'(mie_q);
                    CSR_MTVEC:    r.read_data = mtvec_q;
                    CSR_MSCRATCH: r.read_data = mscratch_q;
                    CSR_MEPC:     r.read_data = mepc_q;
                    CSR_MCAUSE:   r.read_data = mcause_q;
                    CSR_MTVAL:    r.read_data = mtval_q;
                    CSR_MIP:      r.read_data = XLEN'(mip_q);
                    default:      r.status = ST_UNKNOWN;
                endcase
            end
            REQ_WRITE: begin
                case (addr)
                    CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID:
                        r.status = ST_READ_ONLY;
                    CSR_MSTATUS:  mstatus_q = MSTATUS_FIXED | (wd[MSTATUS_W-1:0] & MSTATUS_WMASK);
                    CSR_MISA:     ;
                    CSR_MIE:      mie_q = wd[INT_W-1:0] & INT_WMASK;
                    CSR_MTVEC:    mtvec_q = wd[0] ? (wd & VECTORED_MASK) : (wd & ALIGN4_MASK);
                    CSR_MSCRATCH: mscratch_q = wd;
                    CSR_MEPC:     mepc_q = wd & ALIGN4_MASK;
                    CSR_MCAUSE:   mcause_q = wd & CAUSE_MASK;
                    CSR_MTVAL:    mtval_q = wd;
                    CSR_MIP:      mip_q = wd[INT_W-1:0] & INT_WMASK;
                    default:      r.status = ST_UNKNOWN;
                endcase
            end
            REQ_FETCH: begin
                if (pc[1:0] != 2'b00) begin
                    mtval_q       = pc;
                    mcause_q      = '0;
                    mepc_q        = pc & ALIGN4_MASK;
                    mstatus_q     = TRAP_MSTATUS;
                    r.trap_taken  = 1'b1;
                    r.redirect_pc = mtvec_q & ALIGN4_MASK;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            misa_q       = '0;
            mstatus_q    = '0;
            mie_q        = '0;
            mip_q        = '0;
            mtvec_q      = '0;
            mscratch_q   = '0;
            mepc_q       = '0;
            mcause_q     = '0;
            mtval_q      = '0;
            expected_rsps.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_traps      = 0;
        end else begin
            if (i_cfg_we) begin
                misa_q = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got_rsp = {i_rsp.read_data, i_rsp.status, i_rsp.trap_taken, i_rsp.redirect_pc};
                if (expected_rsps.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected response rd=%h st=%0d trap=%b pc=%h", $realtime,
                                 got_rsp.read_data, got_rsp.status, got_rsp.trap_taken,
                                 got_rsp.redirect_pc);
                    end
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    o_checked++;
                    if (want_rsp.trap_taken) begin
                        o_traps++;
                    end
                    if (got_rsp !== want_rsp) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch exp rd=%h st=%0d trap=%b pc=%h", $realtime,
                                     want_rsp.read_data, want_rsp.status, want_rsp.trap_taken,
                                     want_rsp.redirect_pc);
                            $display("%0t:          got rd=%h st=%0d trap=%b pc=%h", $realtime,
                                     got_rsp.read_data, got_rsp.status, got_rsp.trap_taken,
                                     got_rsp.redirect_pc);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_csr(i_req.req_type, i_req.csr_addr, i_req.write_data, i_req.fetch_pc,
                            new_rsp);
                expected_rsps.push_back(new_rsp);
            end
        end
        o_pending = expected_rsps.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the CSR file testbench: clock, reset, request bursts, response stalls and the
// verdict. Depends on mcsr_pkg, both channel interfaces, mcsr_checker and the block.
module tb;
    import mcsr_pkg::*;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [11:0] ADDR_NONE_LO = 12'h000;
    localparam logic [11:0] ADDR_NONE_HI = 12'hFFF;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          PHASE_ITEMS  = 140;

    typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_SPARSE} stall_mode_t;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [XLEN-1:0] i_cfg_wdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int trap_count;
    int items_sent;
    int isa_settings;
    int burst_left;

    logic [11:0] known_csrs [13] = '{CSR_MSTATUS, CSR_MISA, CSR_MIE, CSR_MTVEC, CSR_MSCRATCH,
                                     CSR_MEPC, CSR_MCAUSE, CSR_MTVAL, CSR_MIP, CSR_MVENDORID,
                                     CSR_MARCHID, CSR_MIMPID, CSR_MHARTID};

    mcsr_req_if req_if ();
    mcsr_rsp_if rsp_if ();

    machine_csr_file_with_fetch_trap u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    mcsr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_traps      (trap_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("timeout with %0d responses outstanding", pending_count);
        $display("machine_csr_file_with_fetch_trap test failed");
        $finish;
    end

    initial begin : receiver
        stall_mode_t mode;
        int          left;
        int          hold;
        rsp_if.ready = 1'b0;
        mode = STALL_NONE;
        left = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(30, 150);
            end
            left--;
            case (mode)
                STALL_NONE: rsp_if.ready <= 1'b1;
                STALL_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
                STALL_LONG: begin
                    if (hold > 0) begin
                        hold--;
                        rsp_if.ready <= 1'b0;
                    end else if ($urandom_range(0, 19) == 0) begin
                        hold = $urandom_range(4, 20);
                        rsp_if.ready <= 1'b0;
                    end else begin
                        rsp_if.ready <= 1'b1;
                    end
                end
                default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Hold valid through a burst; drop it only for a gap.
    task automatic issue(input logic [1:0] rt, input logic [11:0] addr,
                         input logic [63:0] wd, input logic [63:0] pc);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.req_type   <= rt;
        req_if.csr_addr   <= addr;
        req_if.write_data <= wd;
        req_if.fetch_pc   <= pc;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic reprogram_isa(input logic [63:0] value);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        isa_settings++;
    endtask

    task automatic random_request();
        int          pick;
        logic [1:0]  rt;
        logic [11:0] addr;
        logic [63:0] wd;
        logic [63:0] pc;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            rt = REQ_READ;
        end else if (pick < 80) begin
            rt = REQ_WRITE;
        end else if (pick < 97) begin
            rt = REQ_FETCH;
        end else begin
            rt = REQ_UNUSED;
        end
        if ($urandom_range(0, 9) < 8) begin
            addr = known_csrs[$urandom_range(0, 12)];
        end else begin
            addr = 12'($urandom_range(0, 4095));
        end
        case ($urandom_range(0, 15))
            0:       wd = ALL_ONES;
            1:       wd = '0;
            default: wd = {$urandom, $urandom};
        endcase
        pc = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) begin
            pc[1:0] = 2'b00;
        end
        issue(rt, addr, wd, pc);
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_READ;
        req_if.csr_addr   = '0;
        req_if.write_data = '0;
        req_if.fetch_pc   = '0;
        items_sent        = 0;
        isa_settings      = 0;
        burst_left        = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(REQ_READ, CSR_MISA, '0, '0);
        reprogram_isa(ALL_ONES);

        issue(REQ_READ,   CSR_MSTATUS,   '0, '0);
        issue(REQ_WRITE,  CSR_MSTATUS,   ALL_ONES, '0);
        issue(REQ_READ,   CSR_MSTATUS,   '0, '0);
        issue(REQ_WRITE,  CSR_MIE,       ALL_ONES, '0);
        issue(REQ_WRITE,  CSR_MIP,       ALL_ONES, '0);
        issue(REQ_READ,   CSR_MIE,       '0, '0);
        issue(REQ_READ,   CSR_MIP,       '0, '0);
        issue(REQ_WRITE,  CSR_MTVEC,     64'hFFFF_FFFF_FFFF_FFFE, '0);
        issue(REQ_READ,   CSR_MTVEC,     '0, '0);
        issue(REQ_WRITE,  CSR_MTVEC,     ALL_ONES, '0);
        issue(REQ_READ,   CSR_MTVEC,     '0, '0);
        issue(REQ_WRITE,  CSR_MEPC,      ALL_ONES, '0);
        issue(REQ_WRITE,  CSR_MCAUSE,    ALL_ONES, '0);
        issue(REQ_READ,   CSR_MCAUSE,    '0, '0);
        issue(REQ_WRITE,  CSR_MSCRATCH,  ALL_ONES, '0);
        issue(REQ_READ,   CSR_MSCRATCH,  '0, '0);
        issue(REQ_WRITE,  CSR_MIMPID,    ALL_ONES, '0);
        issue(REQ_READ,   CSR_MIMPID,    '0, '0);
        issue(REQ_READ,   CSR_MVENDORID, '0, '0);
        issue(REQ_WRITE,  CSR_MISA,      '0, '0);
        issue(REQ_READ,   CSR_MISA,      '0, '0);
        issue(REQ_READ,   ADDR_NONE_HI,  '0, '0);
        issue(REQ_WRITE,  ADDR_NONE_LO,  ALL_ONES, '0);
        issue(REQ_FETCH,  '0,            '0, ALL_ONES);
        issue(REQ_FETCH,  '0,            '0, '0);
        issue(REQ_UNUSED, ADDR_NONE_HI,  ALL_ONES, ALL_ONES);
        issue(REQ_READ,   CSR_MEPC,      '0, '0);
        issue(REQ_READ,   CSR_MTVAL,     '0, '0);

        reprogram_isa('0);
        repeat (PHASE_ITEMS) random_request();
        reprogram_isa({$urandom, $urandom});
        repeat (PHASE_ITEMS) random_request();
        reprogram_isa(64'h8000_0000_0000_0001);
        repeat (PHASE_ITEMS) random_request();
        reprogram_isa(ALL_ONES);
        repeat (PHASE_ITEMS) random_request();
        reprogram_isa({$urandom, $urandom});
        repeat (PHASE_ITEMS) random_request();

        // Drain outstanding responses, then let the pipeline settle.
        req_if.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("summary: %0d requests sent, %0d responses checked, %0d fetch traps",
                 items_sent, checked_count, trap_count);
        $display("summary: %0d misa settings, %0d failures", isa_settings, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("machine_csr_file_with_fetch_trap test passed");
        end else begin
            $display("machine_csr_file_with_fetch_trap test failed");
        end
        $finish;
    end

endmodule
